### src/tar_header_validator_assert.svh
// Assertion macros for the tar header validator RTL.
`ifndef TAR_HEADER_VALIDATOR_ASSERT_SVH
`define TAR_HEADER_VALIDATOR_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while in reset.
`define THV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("thv assertion failed");
// Next-cycle implication, disabled while in reset.
`define THV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("thv assertion failed");
`else
`define THV_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define THV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### src/thv_pkg.sv
// Types, constants and code points for the tar header validator.
package thv_pkg;

  localparam int THV_COUNT_BITS = 16;

  localparam int BLK_POS_W = 9;
  localparam int SUM_W     = 17;
  localparam int CK_W      = 32;
  localparam int SIZE_W    = 36;
  localparam int BLOCKS_W  = 24;
  localparam int STATUS_W  = 3;
  localparam int HCOUNT_W  = 16;

  // byte offsets inside a 512-byte block
  localparam logic [BLK_POS_W-1:0] POS_FIRST   = 9'd0;
  localparam logic [BLK_POS_W-1:0] POS_LAST    = 9'd511;
  localparam logic [BLK_POS_W-1:0] SIZE_FIRST  = 9'd124;
  localparam logic [BLK_POS_W-1:0] SIZE_LAST   = 9'd135;
  localparam logic [BLK_POS_W-1:0] CK_FIRST    = 9'd148;
  localparam logic [BLK_POS_W-1:0] CK_LAST     = 9'd155;
  localparam logic [BLK_POS_W-1:0] MAGIC_FIRST = 9'd257;
  localparam logic [BLK_POS_W-1:0] MAGIC_LAST  = 9'd262;
  localparam logic [BLK_POS_W-1:0] VER_FIRST   = 9'd263;
  localparam logic [BLK_POS_W-1:0] VER_LAST    = 9'd264;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_SPACE = 8'd32;

  // "ustar\0" followed by "00"
  localparam logic [7:0] MAGIC_TBL [8] = '{8'h75, 8'h73, 8'h74, 8'h61,
                                           8'h72, 8'h00, 8'h30, 8'h30};

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_HALT   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MAGIC    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_VERSION  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CHECKSUM = 3'd3;
  localparam logic [STATUS_W-1:0] ST_END      = 3'd4;

  typedef struct packed {
    logic       start_req;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HCOUNT_W-1:0] header_count;
    logic [BLOCKS_W-1:0] data_blocks;
  } result_t;

endpackage

### src/tar_header_validator.sv
// Top level of the tar ustar header validator.
//
//  channel | direction | ports
//  --------+-----------+-----------------------------------------------------
//  in      | sink      | in_valid, in_ready, in_start_req, in_data_byte
//  out     | source    | out_valid, out_ready, out_status, out_header_count,
//          |           | out_data_blocks
//
// One archive byte is taken per clock unless the out channel stalls; the byte
// that causes a status beat passes the input register, then the result register.
// The core updates its parsing state only when the result register has room,
// so a stalled out channel holds back at most one byte in the input register.
// rst_n is synchronous, active low; it clears all parsing and handshake state.
module tar_header_validator
  import thv_pkg::*;
#(
  parameter int COUNT_BITS = THV_COUNT_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_start_req,
  input  logic [7:0]          in_data_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [HCOUNT_W-1:0] out_header_count,
  output logic [BLOCKS_W-1:0] out_data_blocks
);

  item_t   in_item, item;
  logic    item_valid, step, out_free, res_valid;
  result_t res, out_res;

  assign in_item.start_req = in_start_req;
  assign in_item.data_byte = in_data_byte;
  assign step              = item_valid && out_free;

  thv_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .consume    (step),
    .item_valid (item_valid),
    .item       (item)
  );

  thv_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  thv_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_status       = out_res.status;
  assign out_header_count = out_res.header_count;
  assign out_data_blocks  = out_res.data_blocks;

endmodule

### src/thv_in_reg.sv
// Input register stage: holds one accepted byte until the core consumes it.
module thv_in_reg
  import thv_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  consume,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready   = !valid_r || consume;
  assign valid_nxt  = (in_valid && in_ready) ? 1'b1 : (consume ? 1'b0 : valid_r);
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

### src/thv_core.sv
// Per-byte header parsing, block skipping and status generation.
module thv_core
  import thv_pkg::*;
#(
  parameter int COUNT_BITS = THV_COUNT_BITS
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  output logic    res_valid,
  output result_t res
);

  localparam int CNT_W = (COUNT_BITS < HCOUNT_W) ? COUNT_BITS : HCOUNT_W;

  logic [BLK_POS_W-1:0] pos_r, pos_nxt, pos;
  logic [1:0]           phase_r, phase_nxt, ph;
  logic [BLOCKS_W-1:0]  skip_r, skip_nxt, skip_dec;
  logic [SUM_W-1:0]     sum_r, sum_nxt, sum_base;
  logic [CK_W-1:0]      ck_r, ck_nxt, ck_base;
  logic                 ck_end_r, ck_end_nxt, ck_end_base;
  logic [SIZE_W-1:0]    size_r, size_nxt, size_base;
  logic                 size_end_r, size_end_nxt, size_end_base;
  logic                 magic_bad_r, magic_bad_nxt, magic_bad_base;
  logic                 ver_bad_r, ver_bad_nxt, ver_bad_base;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt, cnt;
  logic [7:0]           b;
  logic                 in_ck, in_size, in_magic, in_ver;
  logic [2:0]           magic_idx;
  logic [SIZE_W:0]      size_round;
  logic [SIZE_W-9:0]    blocks_raw;
  logic [BLOCKS_W-1:0]  blocks_sat;

  assign b         = item.data_byte;
  // start_req behaves as a reset applied just before this byte
  assign pos       = item.start_req ? POS_FIRST : pos_r;
  assign ph        = item.start_req ? PH_HEADER : phase_r;
  assign cnt       = item.start_req ? '0 : cnt_r;
  assign skip_dec  = skip_r - BLOCKS_W'(1);
  assign in_ck     = (pos >= CK_FIRST) && (pos <= CK_LAST);
  assign in_size   = (pos >= SIZE_FIRST) && (pos <= SIZE_LAST);
  assign in_magic  = (pos >= MAGIC_FIRST) && (pos <= MAGIC_LAST);
  assign in_ver    = (pos >= VER_FIRST) && (pos <= VER_LAST);
  assign magic_idx = 3'(pos - MAGIC_FIRST);

  // ceil(size / 512), saturated to the block counter width
  assign size_round = {1'b0, size_nxt} + (SIZE_W+1)'(POS_LAST);
  assign blocks_raw = size_round[SIZE_W:9];
  assign blocks_sat = (blocks_raw[SIZE_W-9:BLOCKS_W] != '0) ? '1
                                                            : blocks_raw[BLOCKS_W-1:0];

  always_comb begin
    pos_nxt        = pos;
    phase_nxt      = ph;
    skip_nxt       = skip_r;
    cnt_nxt        = cnt;
    sum_base       = sum_r;
    ck_base        = ck_r;
    ck_end_base    = ck_end_r;
    size_base      = size_r;
    size_end_base  = size_end_r;
    magic_bad_base = magic_bad_r;
    ver_bad_base   = ver_bad_r;
    if (pos == POS_FIRST) begin
      sum_base       = '0;
      ck_base        = '0;
      ck_end_base    = 1'b0;
      size_base      = '0;
      size_end_base  = 1'b0;
      magic_bad_base = 1'b0;
      ver_bad_base   = 1'b0;
    end
    sum_nxt       = sum_r;
    ck_nxt        = ck_r;
    ck_end_nxt    = ck_end_r;
    size_nxt      = size_r;
    size_end_nxt  = size_end_r;
    magic_bad_nxt = magic_bad_r;
    ver_bad_nxt   = ver_bad_r;
    res_valid     = 1'b0;
    res.status       = ST_OK;
    res.header_count = HCOUNT_W'(cnt);
    res.data_blocks  = '0;

    unique case (ph)
      PH_DATA: begin
        pos_nxt = pos + BLK_POS_W'(1);
        if (pos == POS_LAST) begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            phase_nxt = PH_HEADER;
          end
        end
      end
      PH_HEADER: begin
        if ((pos == POS_FIRST) && (b == 8'd0)) begin
          phase_nxt  = PH_HALT;
          res_valid  = 1'b1;
          res.status = ST_END;
        end else begin
          if ((pos == POS_FIRST) && (cnt != '1)) begin
            cnt_nxt = cnt + CNT_W'(1);
          end
          // checksum field counts as spaces in the sum
          sum_nxt     = sum_base + (in_ck ? SUM_W'(ASCII_SPACE) : SUM_W'(b));
          ck_nxt      = ck_base;
          ck_end_nxt  = ck_end_base;
          if (in_ck && !ck_end_base) begin
            if (b == 8'd0) begin
              ck_end_nxt = 1'b1;
            end else begin
              ck_nxt = {ck_base[CK_W-4:0], 3'b000} + CK_W'(b) - CK_W'(ASCII_ZERO);
            end
          end
          size_nxt     = size_base;
          size_end_nxt = size_end_base;
          if (in_size && !size_end_base) begin
            if (b == 8'd0) begin
              size_end_nxt = 1'b1;
            end else begin
              size_nxt = {size_base[SIZE_W-4:0], 3'b000} + SIZE_W'(b)
                         - SIZE_W'(ASCII_ZERO);
            end
          end
          magic_bad_nxt = magic_bad_base || (in_magic && (b != MAGIC_TBL[magic_idx]));
          ver_bad_nxt   = ver_bad_base || (in_ver && (b != MAGIC_TBL[magic_idx]));
          pos_nxt       = pos + BLK_POS_W'(1);
          if (pos == POS_LAST) begin
            res_valid            = 1'b1;
            res.header_count     = HCOUNT_W'(cnt_nxt);
            if (magic_bad_nxt) begin
              res.status = ST_MAGIC;
              phase_nxt  = PH_HALT;
            end else if (ver_bad_nxt) begin
              res.status = ST_VERSION;
              phase_nxt  = PH_HALT;
            end else if (CK_W'(sum_nxt) != ck_nxt) begin
              res.status = ST_CHECKSUM;
              phase_nxt  = PH_HALT;
            end else begin
              res.status      = ST_OK;
              res.data_blocks = blocks_sat;
              skip_nxt        = blocks_sat;
              phase_nxt       = (blocks_sat != '0) ? PH_DATA : PH_HEADER;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      phase_r     <= PH_HEADER;
      skip_r      <= '0;
      sum_r       <= '0;
      ck_r        <= '0;
      ck_end_r    <= 1'b0;
      size_r      <= '0;
      size_end_r  <= 1'b0;
      magic_bad_r <= 1'b0;
      ver_bad_r   <= 1'b0;
      cnt_r       <= '0;
    end else if (step) begin
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      skip_r      <= skip_nxt;
      sum_r       <= sum_nxt;
      ck_r        <= ck_nxt;
      ck_end_r    <= ck_end_nxt;
      size_r      <= size_nxt;
      size_end_r  <= size_end_nxt;
      magic_bad_r <= magic_bad_nxt;
      ver_bad_r   <= ver_bad_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

`include "tar_header_validator_assert.svh"

  `THV_ASSERT_NOW(a_data_has_blocks, clk, rst_n, phase_r == PH_DATA, skip_r != '0)
  `THV_ASSERT_NEXT(a_err_halts, clk, rst_n, step && res_valid && (res.status != ST_OK), phase_r == PH_HALT)
  `THV_ASSERT_NEXT(a_cnt_monotone, clk, rst_n, step && !item.start_req, cnt_r >= $past(cnt_r))

endmodule

### src/thv_out_reg.sv
// Result register: holds one status beat until the consumer takes it.
module thv_out_reg
  import thv_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  output logic    out_free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign out_free  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule
